>>> rtl/rfed_pkg.sv
// rfed_pkg: types, timing windows and register map of the remote edge decoder
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package rfed_pkg;

    // field widths
    localparam int TIME_W = 16;
    localparam int CODE_W = 32;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 5;

    // stream and register port widths
    localparam int IN_TDATA_W = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // pulse windows in 10 us ticks
    localparam logic [TIME_W-1:0] HDR_MARK_MIN = 16'd40;
    localparam logic [TIME_W-1:0] HDR_SPACE_LO = 16'd930;
    localparam logic [TIME_W-1:0] HDR_SPACE_HI = 16'd1550;
    localparam logic [TIME_W-1:0] BIT_SPACE_LO = 16'd20;
    localparam logic [TIME_W-1:0] BIT_SPACE_HI = 16'd180;
    localparam logic [TIME_W-1:0] ONE_LIMIT    = 16'd80;

    // bit counter limits
    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

    // register map, indexed by paddr[2]
    localparam logic REG_FRAME_BITS = 1'b0;
    localparam logic [CNT_W-1:0] FRAME_BITS_RST = 6'd24;

    // receive phases
    typedef enum logic [1:0] {
        PH_WAIT_MARK   = 2'd0,
        PH_WAIT_HSPACE = 2'd1,
        PH_WAIT_FIRST  = 2'd2,
        PH_DATA        = 2'd3
    } phase_t;

    // one result word
    typedef struct packed {
        logic              frame_done;
        logic [CODE_W-1:0] code;
    } result_t;

endpackage

>>> rtl/rfed_cfg.sv
// rfed_cfg: APB register file holding the frame length
// depends on rfed_pkg
`timescale 1ns / 1ps

module rfed_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rfed_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rfed_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rfed_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [rfed_pkg::CNT_W-1:0]       frame_bits
);
    import rfed_pkg::*;

    logic [CNT_W-1:0] frame_bits_reg;
    logic [CNT_W-1:0] frame_bits_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        frame_bits_next = frame_bits_reg;
        if (wr_en && (paddr[2] == REG_FRAME_BITS))
        begin
            frame_bits_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits_reg <= FRAME_BITS_RST;
        end
        else
        begin
            frame_bits_reg <= frame_bits_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_BITS)
        begin
            prdata = {{(APB_DATA_W-CNT_W){1'b0}}, frame_bits_reg};
        end
    end

    assign frame_bits = frame_bits_reg;

endmodule

>>> rtl/rfed_core.sv
// rfed_core: pulse width state machine, bit counter and shift word
// depends on rfed_pkg
`timescale 1ns / 1ps

module rfed_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic                         pin_level,
    input  logic [rfed_pkg::TIME_W-1:0]  edge_time,
    input  logic [rfed_pkg::CNT_W-1:0]   frame_bits,
    output rfed_pkg::result_t            result
);
    import rfed_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TIME_W-1:0]  last_time_reg;
    logic [CODE_W-1:0]  shift_reg;
    logic [CODE_W-1:0]  shift_next;
    logic [CNT_W-1:0]   bits_reg;
    logic [CNT_W-1:0]   bits_next;

    logic [TIME_W-1:0]  dur;
    logic               mark_ok;
    logic               hspace_ok;
    logic               bit_ok;
    logic               bit_one;
    logic [CNT_W-1:0]   bits_inc;
    logic [CODE_W-1:0]  shift_set;
    logic               frame_full;

    // duration since previous edge, wraps mod 2^16
    assign dur       = edge_time - last_time_reg;
    assign mark_ok   = dur > HDR_MARK_MIN;
    assign hspace_ok = (dur >= HDR_SPACE_LO) && (dur <= HDR_SPACE_HI);
    assign bit_ok    = (dur >= BIT_SPACE_LO) && (dur <= BIT_SPACE_HI);
    assign bit_one   = dur < ONE_LIMIT;

    // saturating bit count, bits past 31 are dropped from the word
    assign bits_inc   = (bits_reg == CNT_MAX) ? CNT_MAX : bits_reg + 6'd1;
    assign shift_set  = (bit_one && !bits_reg[CNT_W-1])
                        ? (shift_reg | (CODE_W'(1) << bits_reg[IDX_W-1:0]))
                        : shift_reg;
    assign frame_full = bits_inc >= frame_bits;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (!pin_level)
        begin
            unique case (phase_reg)
                PH_WAIT_MARK:   phase_next = mark_ok ? PH_WAIT_HSPACE : PH_WAIT_MARK;
                PH_WAIT_HSPACE: phase_next = PH_WAIT_MARK;
                PH_WAIT_FIRST:  phase_next = PH_DATA;
                PH_DATA:        phase_next = PH_DATA;
                default:        phase_next = PH_WAIT_MARK;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_WAIT_HSPACE: phase_next = hspace_ok ? PH_WAIT_FIRST : PH_WAIT_MARK;
                PH_DATA:        phase_next = (bit_ok && !frame_full) ? PH_DATA : PH_WAIT_MARK;
                default:        phase_next = PH_WAIT_MARK;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        shift_next        = shift_reg;
        bits_next         = bits_reg;
        result.frame_done = 1'b0;
        result.code       = '0;
        if (!pin_level && (phase_reg == PH_WAIT_FIRST))
        begin
            shift_next = '0;
            bits_next  = '0;
        end
        else if (pin_level && (phase_reg == PH_DATA) && bit_ok)
        begin
            shift_next = shift_set;
            bits_next  = bits_inc;
            if (frame_full)
            begin
                result.frame_done = 1'b1;
                result.code       = shift_set;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_MARK;
            last_time_reg <= '0;
            shift_reg     <= '0;
            bits_reg      <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            last_time_reg <= edge_time;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a completed frame always restarts the search for a header
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.frame_done |=> phase_reg == PH_WAIT_MARK)
        else $error("frame done did not return to header search");

    // the first data mark clears the collected bits
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !pin_level && (phase_reg == PH_WAIT_FIRST)
        |=> (bits_reg == '0) && (shift_reg == '0) && (phase_reg == PH_DATA))
        else $error("first data mark did not clear the shift word");

    // every accepted edge becomes the new time reference
    a_time_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> last_time_reg == $past(edge_time))
        else $error("edge time reference not updated");

    // the code is zero unless the frame is done
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result.frame_done |-> result.code == '0)
        else $error("code nonzero without frame done");
`endif

endmodule

>>> rtl/rf_remote_edge_decoder.sv
// rf_remote_edge_decoder: stream wrapper with input and result registers
// depends on rfed_pkg, rfed_cfg, rfed_core
// result path: edge word into the input register, then its result word into the result register
// throughput: one edge word per cycle when not stalled; state loop: one compare-and-update step
// while a result word waits at the output, at most one more input word is taken; s_tready drops
// reset: rst_n asynchronous active low; phase to header search, time, bits
//   and code cleared, frame length back to 24
`timescale 1ns / 1ps

module rf_remote_edge_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // edge stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rfed_pkg::IN_TDATA_W-1:0]     s_tdata,   // pin_level [0], edge_time [16:1], zero
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rfed_pkg::CODE_W-1:0]         m_tdata,   // code [31:0]
    output logic                                m_tlast,   // frame_done
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rfed_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rfed_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rfed_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rfed_pkg::*;

    logic               in_valid_reg;
    logic               in_level_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            core_res;
    logic [CNT_W-1:0]   frame_bits;
    logic               advance;
    logic               in_accept;

    // pipeline moves when the result slot is free or being drained
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    rfed_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frame_bits (frame_bits)
    );

    rfed_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_valid_reg && advance),
        .pin_level  (in_level_reg),
        .edge_time  (in_time_reg),
        .frame_bits (frame_bits),
        .result     (core_res)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[TIME_W:1];
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.code;
    assign m_tlast  = out_reg.frame_done;

`ifndef NO_ASSERTIONS
    // a waiting result is not overwritten by the next edge
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("pending result overwritten");

    // an accepted edge word reaches the core on the next cycle
    a_in_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg && (in_time_reg == $past(s_tdata[TIME_W:1])))
        else $error("accepted edge word not loaded");

    // a held edge word moves to the result register once the output drains
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("edge word lost between stages");
`endif

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for rf_remote_edge_decoder, edge words in, result words out
// depends on rfed_pkg and rf_remote_edge_decoder; a scoreboard class predicts each result word
`timescale 1ns / 1ps

module testbench;

    import rfed_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;
    localparam int LONG_HOLD   = 300;
    localparam logic [APB_ADDR_W-1:0] FRAME_BITS_ADDR = {REG_FRAME_BITS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR     = {~REG_FRAME_BITS, 2'b00};

    // frame length per random phase: reset value, extremes, above the code width
    localparam logic [CNT_W-1:0] FRAME_LEN_SET [8] =
        '{6'd24, 6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd40, 6'd13};

    // edge decoder scoreboard: tracks receive state and holds expected result words
    class frame_tracker;
        logic [CNT_W-1:0]  frame_len;
        phase_t            rx_state;
        logic [TIME_W-1:0] prev_time;
        logic [CODE_W-1:0] code_acc;
        logic [CNT_W-1:0]  bit_cnt;
        result_t           expected_words[$];
        int                errors;

        function new();
            frame_len = FRAME_BITS_RST;
            rx_state  = PH_WAIT_MARK;
            prev_time = '0;
            code_acc  = '0;
            bit_cnt   = '0;
            errors    = 0;
        endfunction

        function void set_frame_len(logic [APB_DATA_W-1:0] value);
            frame_len = value[CNT_W-1:0];
        endfunction

        // predict the result word caused by one accepted edge
        function void accept_edge(logic level, logic [TIME_W-1:0] stamp);
            logic [TIME_W-1:0] gap;
            result_t           res;
            gap       = stamp - prev_time;
            prev_time = stamp;
            res       = '0;
            if (!level)
            begin
                // falling edge ends a mark
                case (rx_state)
                    PH_WAIT_MARK:   if (gap > HDR_MARK_MIN) rx_state = PH_WAIT_HSPACE;
                    PH_WAIT_HSPACE: rx_state = PH_WAIT_MARK;
                    PH_WAIT_FIRST:
                    begin
                        bit_cnt  = '0;
                        code_acc = '0;
                        rx_state = PH_DATA;
                    end
                    default: ;
                endcase
            end
            else if (rx_state == PH_WAIT_HSPACE)
            begin
                rx_state = (gap >= HDR_SPACE_LO && gap <= HDR_SPACE_HI) ? PH_WAIT_FIRST
                                                                         : PH_WAIT_MARK;
            end
            else if (rx_state == PH_DATA && gap >= BIT_SPACE_LO && gap <= BIT_SPACE_HI)
            begin
                // short space is a one, bits past the code width are only counted
                if (gap < ONE_LIMIT && bit_cnt < CODE_W)
                    code_acc[bit_cnt[4:0]] = 1'b1;
                if (bit_cnt < CNT_MAX)
                    bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt >= frame_len)
                begin
                    res.frame_done = 1'b1;
                    res.code       = code_acc;
                    rx_state       = PH_WAIT_MARK;
                end
            end
            else
            begin
                rx_state = PH_WAIT_MARK;
            end
            expected_words.push_back(res);
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(logic done, logic [CODE_W-1:0] code);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, actual done %0b code %h",
                         $time, done, code);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (done !== want.frame_done)
            begin
                $display("%0t: frame_done mismatch, expected %0b actual %0b",
                         $time, want.frame_done, done);
                errors++;
            end
            if (code !== want.code)
            begin
                $display("%0t: code mismatch, expected %h actual %h", $time, want.code, code);
                errors++;
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CODE_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_tracker      tracker   = new();
    logic [TIME_W-1:0] tick_now  = '0;
    int                items_sent = 0;
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                cycles    = 0;
    logic              hold_req  = 1'b0;
    logic              hold_used = 1'b0;
    int                hold_left = 0;

    rf_remote_edge_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // pin_level [0], edge_time [16:1], zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // code [31:0]
        .m_tlast  (m_tlast),   // frame_done
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached, %0d result words outstanding",
                     $time, tracker.expected_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check words, random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tlast, m_tdata);
        if (hold_req && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // register write: setup phase, access phase until pready, then back to idle
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_FRAME_BITS)
            tracker.set_frame_len(data);
        @(posedge clk);
    endtask

    // offer one edge word, with random idle cycles ahead of it
    task automatic send_edge(input logic level, input logic [TIME_W-1:0] stamp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-TIME_W-1){1'b0}}, stamp, level};
        do @(posedge clk); while (!s_tready);
        tracker.accept_edge(level, stamp);
        items_sent++;
    endtask

    task automatic edge_after(input logic level, input logic [TIME_W-1:0] gap);
        tick_now = tick_now + gap;
        send_edge(level, tick_now);
    endtask

    // gap inside a window, biased to its ends; a corrupt pick may fall just outside or be fully random
    function automatic logic [TIME_W-1:0] pick_gap(input int lo, input int hi, input bit corrupt);
        int roll;
        roll = $urandom_range(31);
        if (corrupt && roll == 0)
            return TIME_W'(lo - 1);
        if (corrupt && roll == 1)
            return TIME_W'(hi + 1);
        if (corrupt && roll == 2)
            return TIME_W'($urandom_range(65535));
        if (roll < 6)
            return TIME_W'(lo);
        if (roll < 10)
            return TIME_W'(hi);
        return TIME_W'($urandom_range(hi, lo));
    endfunction

    // header mark, header space, first mark, then one space and mark per bit
    task automatic send_frame(input bit corrupt);
        int nbits;
        nbits = (tracker.frame_len == 0) ? 1 : int'(tracker.frame_len);
        if (corrupt && $urandom_range(1))
            nbits = $urandom_range(nbits);
        edge_after(1'b1, pick_gap(1600, 20000, corrupt));
        edge_after(1'b0, pick_gap(41, 1200, corrupt));
        edge_after(1'b1, pick_gap(930, 1550, corrupt));
        edge_after(1'b0, pick_gap(0, 200, corrupt));
        for (int i = 0; i < nbits; i++)
        begin
            if (i != 0)
                edge_after(1'b0, pick_gap(0, 200, corrupt));
            if ($urandom_range(1))
                edge_after(1'b1, pick_gap(20, 79, corrupt));
            else
                edge_after(1'b1, pick_gap(80, 180, corrupt));
        end
    endtask

    // random edges with random levels and gaps
    task automatic send_noise();
        int count;
        count = $urandom_range(8, 1);
        repeat (count)
            edge_after(1'($urandom_range(1)),
                       TIME_W'($urandom_range(1) ? $urandom_range(65535)
                                                 : $urandom_range(300)));
    endtask

    // stop offering and wait for every expected word
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int phase_start;
        int roll;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: window edges, rejects, a short frame and a timestamp wrap
        write_reg(FRAME_BITS_ADDR, 32'd2);
        edge_after(1'b1, 16'd10);
        edge_after(1'b0, 16'd40);     // mark too short
        edge_after(1'b1, 16'd5);
        edge_after(1'b0, 16'd41);
        edge_after(1'b1, 16'd929);    // header space too short
        edge_after(1'b0, 16'd41);
        edge_after(1'b1, 16'd1551);   // header space too long
        edge_after(1'b0, 16'd41);
        edge_after(1'b1, 16'd930);
        edge_after(1'b0, 16'd0);
        edge_after(1'b1, 16'd19);     // bit space too short
        edge_after(1'b0, 16'd41);
        edge_after(1'b1, 16'd1550);
        edge_after(1'b0, 16'd5);
        edge_after(1'b1, 16'd20);
        edge_after(1'b0, 16'd5);
        edge_after(1'b1, 16'd80);
        tick_now = 16'hFC00;
        edge_after(1'b1, 16'd0);
        edge_after(1'b0, 16'd41);
        edge_after(1'b1, 16'd1000);   // header space across the timestamp wrap
        edge_after(1'b0, 16'd3);
        edge_after(1'b1, 16'd180);
        edge_after(1'b0, 16'd3);
        edge_after(1'b1, 16'd79);
        drain();

        // random phases over idle modes and frame lengths
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    idle_pct  = 35;
                    stall_pct = 35;
                end
            endcase
            write_reg(FRAME_BITS_ADDR, ($urandom() & ~32'h3F) | FRAME_LEN_SET[p]);
            if (p == 5)
                write_reg(UNUSED_ADDR, $urandom());
            if (p == 0)
                hold_req <= 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                    send_frame(1'b0);
                else if (roll < 92)
                    send_frame(1'b1);
                else
                    send_noise();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (tracker.expected_words.size() != 0)
            $display("%0t: %0d expected result words never arrived",
                     $time, tracker.expected_words.size());
        if (tracker.errors == 0 && tracker.expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
